// File: src/tok_dfa_pkg.sv
// Shared types and constants for the table-driven token automaton.
// Holds the word layouts of both channels, operation codes and the state-to-type map.
// No dependencies.
package tok_dfa_pkg;

  localparam int DFA_ROWS    = 32;
  localparam int NUM_CLASSES = 16;
  localparam int STATE_W     = 5;
  localparam int CLASS_W     = 4;
  localparam int MASK_W      = 16;

  localparam logic [2:0] OP_WR_CLASS = 3'd0;
  localparam logic [2:0] OP_WR_TRANS = 3'd1;
  localparam logic [2:0] OP_WR_FINAL = 3'd2;
  localparam logic [2:0] OP_FEED     = 3'd3;
  localparam logic [2:0] OP_END      = 3'd4;

  localparam logic [2:0] TT_REJECT  = 3'd0;
  localparam logic [2:0] TT_INTEGER = 3'd1;
  localparam logic [2:0] TT_REAL    = 3'd2;
  localparam logic [2:0] TT_OPER    = 3'd3;
  localparam logic [2:0] TT_SERVICE = 3'd4;
  localparam logic [2:0] TT_IDENT   = 3'd5;
  localparam logic [2:0] TT_KEYWORD = 3'd6;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         char_code;
    logic [MASK_W-1:0]  class_mask;
    logic [STATE_W-1:0] row_state;
    logic [CLASS_W-1:0] class_index;
    logic [STATE_W-1:0] target_state;
    logic               target_valid;
    logic               final_flag;
  } in_t;

  typedef struct packed {
    logic [STATE_W-1:0] state_now;
    logic               dead;
    logic               token_done;
    logic [2:0]         token_type;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] target;
  } trans_entry_t;

  typedef trans_entry_t [NUM_CLASSES-1:0] trans_row_t;

  // Fixed map from automaton state to token category
  function automatic logic [2:0] kind_of_state(input logic [STATE_W-1:0] st);
    logic [2:0] kind;
    unique case (st)
      5'd1, 5'd2, 5'd3:                 kind = TT_INTEGER;
      5'd5:                             kind = TT_REAL;
      5'd6:                             kind = TT_OPER;
      5'd7:                             kind = TT_SERVICE;
      5'd8, 5'd9, 5'd11, 5'd12, 5'd13,
      5'd14, 5'd15, 5'd16:              kind = TT_IDENT;
      5'd10, 5'd17:                     kind = TT_KEYWORD;
      default:                          kind = TT_REJECT;
    endcase
    return kind;
  endfunction

endpackage

// File: src/table_driven_token_dfa.sv
// Table-driven token automaton: class, transition and accepting stores plus the stepper.
// Depends on tok_dfa_pkg.
//
// Usage: one input word carries an operation (write class mask, write transition,
// write accepting flag, feed byte, end token) and its operands; every input word gives
// exactly one output word with the state after the word, the dead flag, and on an end
// operation the token type.
// Channels: in_valid/in_stall/in_word and out_valid/out_stall/out_word; a word moves at
// a rising edge with valid high and stall low.
// Timing: a word accepted at a rising edge is read from the stores at that edge into the
// read registers, resolved by the priority select and placed in the output register once
// that register is free; no new word is taken until then. The registered read of the class
// memory and of the transition row memory must precede the priority select.
// The transition memory keeps one whole row per state; a single-entry write is a
// read, merge and write back of that row.
// Reset: synchronous, active high; state 0, no dead token, all stores read as cleared
// through per-entry valid bits (classes) and per-row valid bits (transitions) at once.
// Receiver stall: the output word holds; a word already in work waits for the output
// register and in_stall stays high until it has moved.
module table_driven_token_dfa (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tok_dfa_pkg::in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output tok_dfa_pkg::out_t out_word
);

  typedef enum logic {IDLE, EXEC} phase_t;

  phase_t                          ph;
  tok_dfa_pkg::in_t                item;
  logic [tok_dfa_pkg::STATE_W-1:0] cur_state;
  logic [tok_dfa_pkg::STATE_W-1:0] state_next;
  logic                            dead_flag;
  logic                            dead_next;

  logic [tok_dfa_pkg::MASK_W-1:0]  cls_mem [256];
  logic [tok_dfa_pkg::MASK_W-1:0]  cls_rd;
  logic [255:0]                    cls_vld;
  logic                            cls_rd_vld;

  tok_dfa_pkg::trans_row_t         trans_mem [tok_dfa_pkg::DFA_ROWS];
  tok_dfa_pkg::trans_row_t         row_rd;
  tok_dfa_pkg::trans_row_t         row_eff;
  tok_dfa_pkg::trans_row_t         row_wr;
  logic [tok_dfa_pkg::DFA_ROWS-1:0] row_vld;
  logic                            row_rd_vld;
  logic [tok_dfa_pkg::STATE_W-1:0] row_raddr;

  logic [tok_dfa_pkg::DFA_ROWS-1:0] acc_flags;

  logic [tok_dfa_pkg::MASK_W-1:0]  mask_eff;
  logic                            hit;
  logic [tok_dfa_pkg::STATE_W-1:0] hit_target;
  tok_dfa_pkg::trans_entry_t       new_entry;

  logic                            accept;
  logic                            finish;
  logic                            cls_we;
  logic                            trans_we;
  logic                            final_we;
  tok_dfa_pkg::out_t               result;

  assign in_stall = (ph != IDLE);
  assign accept   = in_valid && (ph == IDLE);
  assign finish   = (ph == EXEC) && (!out_valid || !out_stall);

  assign cls_we   = finish && (item.operation == tok_dfa_pkg::OP_WR_CLASS);
  assign trans_we = finish && (item.operation == tok_dfa_pkg::OP_WR_TRANS)
                    && (32'(item.row_state) < tok_dfa_pkg::DFA_ROWS)
                    && (32'(item.class_index) < tok_dfa_pkg::NUM_CLASSES);
  assign final_we = finish && (item.operation == tok_dfa_pkg::OP_WR_FINAL)
                    && (32'(item.row_state) < tok_dfa_pkg::DFA_ROWS);

  // Transition writes read their own row, feeds read the row of the current state
  assign row_raddr = (in_word.operation == tok_dfa_pkg::OP_WR_TRANS) ?
                     in_word.row_state : cur_state;

  assign mask_eff = cls_rd_vld ? cls_rd : '0;
  assign row_eff  = row_rd_vld ? row_rd : '0;

  // Lowest-numbered class with a live transition that holds the byte
  always_comb begin
    hit        = 1'b0;
    hit_target = '0;
    for (int c = 0; c < tok_dfa_pkg::NUM_CLASSES; c++) begin
      if (!hit && row_eff[c].valid && mask_eff[c]) begin
        hit        = 1'b1;
        hit_target = row_eff[c].target;
      end
    end
  end

  always_comb begin
    new_entry.valid  = item.target_valid
                       && (32'(item.target_state) < tok_dfa_pkg::DFA_ROWS);
    new_entry.target = new_entry.valid ? item.target_state : '0;
    row_wr = row_eff;
    row_wr[item.class_index] = new_entry;
  end

  always_comb begin
    state_next        = cur_state;
    dead_next         = dead_flag;
    result.state_now  = cur_state;
    result.dead       = dead_flag;
    result.token_done = 1'b0;
    result.token_type = tok_dfa_pkg::TT_REJECT;
    unique case (item.operation)
      tok_dfa_pkg::OP_FEED: begin
        if (!dead_flag) begin
          if (hit) begin
            state_next = hit_target;
          end else begin
            dead_next = 1'b1;
          end
        end
        result.state_now = state_next;
        result.dead      = dead_next;
      end
      tok_dfa_pkg::OP_END: begin
        state_next        = '0;
        dead_next         = 1'b0;
        result.state_now  = '0;
        result.token_done = 1'b1;
        if (!dead_flag && acc_flags[cur_state]) begin
          result.token_type = tok_dfa_pkg::kind_of_state(cur_state);
        end
      end
      default: begin
      end
    endcase
  end

  // Class membership memory
  always_ff @(posedge clk) begin
    if (accept) begin
      cls_rd <= cls_mem[in_word.char_code];
    end
    if (cls_we) begin
      cls_mem[item.char_code] <= item.class_mask;
    end
  end

  // Transition row memory
  always_ff @(posedge clk) begin
    if (accept) begin
      row_rd <= trans_mem[row_raddr];
    end
    if (trans_we) begin
      trans_mem[item.row_state] <= row_wr;
    end
  end

  // Valid bits, accepting flags and automaton state
  always_ff @(posedge clk) begin
    if (rst) begin
      cls_vld    <= '0;
      row_vld    <= '0;
      acc_flags  <= '0;
      cls_rd_vld <= 1'b0;
      row_rd_vld <= 1'b0;
      cur_state  <= '0;
      dead_flag  <= 1'b0;
    end else begin
      if (accept) begin
        cls_rd_vld <= cls_vld[in_word.char_code];
        row_rd_vld <= row_vld[row_raddr];
      end
      if (cls_we) begin
        cls_vld[item.char_code] <= 1'b1;
      end
      if (trans_we) begin
        row_vld[item.row_state] <= 1'b1;
      end
      if (final_we) begin
        acc_flags[item.row_state] <= item.final_flag;
      end
      if (finish) begin
        cur_state <= state_next;
        dead_flag <= dead_next;
      end
    end
  end

  // Phase and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_word  <= result;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (ph)
        IDLE: begin
          if (accept) begin
            item <= in_word;
            ph   <= EXEC;
          end
        end
        EXEC: begin
          if (finish) begin
            ph <= IDLE;
          end
        end
        default: ph <= IDLE;
      endcase
    end
  end

  // An item in work with an empty output register completes in that cycle
  a_exec_completes: assert property (@(posedge clk) disable iff (rst)
    (ph == EXEC && !out_valid) |=> (out_valid && ph == IDLE))
    else $error("item in work did not reach the output register");

  // An end word always reports the return to the start state
  a_end_state_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.token_done) |-> (out_word.state_now == '0))
    else $error("end word reports a non-zero state");

  // A recognised type only on an end word of a live token
  a_type_only_live_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.token_type != tok_dfa_pkg::TT_REJECT)
      |-> (out_word.token_done && !out_word.dead))
    else $error("token type given outside a live end word");

  // Finishing an end operation clears the automaton
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (finish && item.operation == tok_dfa_pkg::OP_END) |=> (cur_state == '0 && !dead_flag))
    else $error("end operation left the automaton dirty");

endmodule
